### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

### hw/rtl/sph_pkg.sv
// Types and constants for the symbol price hash table.
// Depends on nothing; used by the front, queue, back and top-level modules.
package sph_pkg;
	localparam int KEY_W = 64;
	localparam int PRICE_W = 48;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_MUL = 32'd16777619;
	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NEW = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic op;
		logic [KEY_W-1:0] key;
		logic [PRICE_W-1:0] price;
		logic [31:0] hash;
	} req_t;

	typedef struct packed {
		logic found;
		logic [PRICE_W-1:0] price;
		logic [1:0] status;
	} resp_t;
endpackage

### hw/rtl/sph_front.sv
// Front part: accepts request words, trims the key and hashes it with FNV-1a.
// Depends on sph_pkg.
module sph_front #(
	parameter int KEY_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_op,
	input logic [sph_pkg::KEY_W-1:0] in_symbol,
	input logic [sph_pkg::PRICE_W-1:0] in_price,
	output logic out_valid,
	input logic out_ready,
	output sph_pkg::req_t out_req
);
	localparam int NB = (KEY_BYTES < 8) ? KEY_BYTES : 8;
	localparam int CW = $clog2(NB + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] len_q;
	sph_pkg::req_t req_q;
	logic [sph_pkg::KEY_W-1:0] key_c;
	logic [CW-1:0] len_c;
	logic stop_c;
	logic [7:0] byte_c;
	logic [31:0] mul_c;

	always_comb begin
		key_c = '0;
		len_c = CW'(NB);
		stop_c = 1'b0;
		for (int i = 0; i < NB; i++) begin
			if (!stop_c && in_symbol[8*i +: 8] == 8'd0) begin
				stop_c = 1'b1;
				len_c = CW'(i);
			end
			if (!stop_c) begin
				key_c[8*i +: 8] = in_symbol[8*i +: 8];
			end
		end
	end

	assign byte_c = req_q.key[8*idx_q +: 8];
	assign mul_c = (req_q.hash ^ {24'd0, byte_c}) * sph_pkg::FNV_MUL;
	assign in_ready = !busy_q && !done_q;
	assign out_valid = done_q;
	assign out_req = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
			len_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				len_q <= len_c;
			end else if (busy_q) begin
				if (idx_q == len_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (done_q && out_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q.op <= in_op;
			req_q.key <= key_c;
			req_q.price <= in_price;
			req_q.hash <= sph_pkg::FNV_BASIS;
		end else if (busy_q && idx_q != len_q) begin
			req_q.hash <= mul_c;
		end
	end
endmodule

### hw/rtl/sph_queue.sv
// Two-entry queue of hashed requests between the front and back parts.
// Depends on sph_pkg.
module sph_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sph_pkg::req_t in_req,
	output logic out_valid,
	input logic out_ready,
	output sph_pkg::req_t out_req
);
	sph_pkg::req_t mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic wr;
	logic rd;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_req = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_req;
	end
endmodule

### hw/rtl/sph_back.sv
// Back part: walks a bucket chain in the pool to look up, update or append.
// Depends on sph_pkg.
module sph_back #(
	parameter int BUCKETS = 256,
	parameter int POOL_ENTRIES = 512
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] bucket_mask,
	input logic in_valid,
	output logic in_ready,
	input sph_pkg::req_t in_req,
	output logic out_valid,
	input logic out_ready,
	output sph_pkg::resp_t out_resp
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CLRW = BW + 1;

	typedef enum logic [6:0] {
		S_CLR = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_HEAD = 7'b0000100,
		S_READ = 7'b0001000,
		S_CMP = 7'b0010000,
		S_DONE = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CLRW-1:0] clr_q;
	logic [PW:0] fill_q;
	sph_pkg::req_t req_q;
	logic [BW-1:0] bkt_q;
	logic [PW:0] head_rd_q;
	logic have_q;
	logic [PW-1:0] cur_q;
	logic [PW-1:0] tail_q;
	logic hit_q;
	logic [PW:0] steps_q;

	logic [PW:0] head_mem [BUCKETS];
	logic [sph_pkg::KEY_W-1:0] sym_mem [POOL_ENTRIES];
	logic [sph_pkg::PRICE_W-1:0] price_mem [POOL_ENTRIES];
	logic [PW:0] link_mem [POOL_ENTRIES];
	logic [sph_pkg::KEY_W-1:0] sym_rd_q;
	logic [sph_pkg::PRICE_W-1:0] price_rd_q;
	logic [PW:0] link_rd_q;
	sph_pkg::resp_t resp_q;

	logic [31:0] masked;
	logic [BW-1:0] bkt_c;
	logic head_we;
	logic [BW-1:0] head_wa;
	logic [PW:0] head_wd;
	logic full;

	assign masked = in_req.hash & {24'd0, bucket_mask};
	assign bkt_c = BW'(masked % BUCKETS);
	assign full = fill_q >= (PW+1)'(POOL_ENTRIES);
	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_resp = resp_q;

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = {1'b1, fill_q[PW-1:0]};
		if (state_q == S_CLR) begin
			head_we = 1'b1;
			head_wa = clr_q[BW-1:0];
			head_wd = '0;
		end else if (state_q == S_DONE && !hit_q && req_q.op == sph_pkg::OP_SET
				&& !full && !have_q) begin
			head_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[bkt_q];
		sym_rd_q <= sym_mem[cur_q];
		price_rd_q <= price_mem[cur_q];
		link_rd_q <= link_mem[cur_q];
		if (state_q == S_DONE && req_q.op == sph_pkg::OP_SET) begin
			if (hit_q) begin
				price_mem[cur_q] <= req_q.price;
			end else if (!full) begin
				sym_mem[fill_q[PW-1:0]] <= req_q.key;
				price_mem[fill_q[PW-1:0]] <= req_q.price;
				link_mem[fill_q[PW-1:0]] <= '0;
				if (have_q) link_mem[tail_q] <= {1'b1, fill_q[PW-1:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_req;
			bkt_q <= bkt_c;
		end
		if (state_q == S_DONE) begin
			resp_q.found <= hit_q;
			if (hit_q) begin
				resp_q.price <= (req_q.op == sph_pkg::OP_SET) ? req_q.price : price_rd_q;
				resp_q.status <= sph_pkg::ST_OK;
			end else if (req_q.op == sph_pkg::OP_SET) begin
				resp_q.price <= full ? '0 : req_q.price;
				resp_q.status <= full ? sph_pkg::ST_FULL : sph_pkg::ST_NEW;
			end else begin
				resp_q.price <= '0;
				resp_q.status <= sph_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			fill_q <= '0;
			have_q <= 1'b0;
			cur_q <= '0;
			tail_q <= '0;
			hit_q <= 1'b0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRW'(BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_HEAD;
				end
				S_HEAD: begin
					state_q <= S_READ;
				end
				S_READ: begin
					have_q <= head_rd_q[PW];
					cur_q <= head_rd_q[PW-1:0];
					tail_q <= head_rd_q[PW-1:0];
					hit_q <= 1'b0;
					steps_q <= '0;
					state_q <= head_rd_q[PW] ? S_CMP : S_DONE;
				end
				S_CMP: begin
					// The pool read for cur_q is registered, so it lands in the cycle after cur_q changes.
					if (steps_q[0] == 1'b0) begin
						steps_q <= steps_q + 1'b1;
					end else if (sym_rd_q == req_q.key) begin
						hit_q <= 1'b1;
						state_q <= S_DONE;
					end else if (!link_rd_q[PW]) begin
						tail_q <= cur_q;
						state_q <= S_DONE;
					end else begin
						tail_q <= cur_q;
						cur_q <= link_rd_q[PW-1:0];
						steps_q <= '0;
					end
				end
				S_DONE: begin
					if (!hit_q && req_q.op == sph_pkg::OP_SET && !full) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/symbol_price_hash_table.sv
// Top level of the symbol price hash table.
// Depends on sph_pkg, sph_front, sph_queue and sph_back.
//
// Request words enter on the s_axis channel: op selects a set or a look-up,
// the symbol is up to eight ASCII bytes with the first in the low byte, and
// new_price is the price stored on a set. Each request gives one response
// word on m_axis with found, price and status.
// The front part hashes the key with FNV-1a, one byte a cycle, and accepts
// a new word only after it has handed the last one on to the queue.
// A two-word queue then feeds the back part, which reads the bucket head and
// walks the chain through the pool memories, waiting for each entry's
// registered read before comparing the key; it takes a new word only after
// its last response is taken. Front and back work on different words at once.
// The user must write bucket_mask on the cfg channel only while the block
// is idle; the block itself does not enforce it. After reset the back part
// clears the bucket heads, one a cycle, before it takes a request; the front
// still hashes. A stalled receiver holds the response in the back part; the
// queue and the front keep taking words until both are full.
module symbol_price_hash_table #(
	parameter int BUCKETS = 256,
	parameter int POOL_ENTRIES = 512,
	parameter int KEY_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [111:0] s_axis_tdata, // symbol[63:0], new_price[111:64]
	input logic s_axis_tuser, // op
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata, // found[0], price[48:1], status[50:49], zero
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);
	logic [7:0] bucket_mask_q;
	logic f_valid;
	logic f_ready;
	sph_pkg::req_t f_req;
	logic q_valid;
	logic q_ready;
	sph_pkg::req_t q_req;
	sph_pkg::resp_t resp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_mask_q <= 8'd255;
		end else if (cfg_valid) begin
			bucket_mask_q <= cfg_data;
		end
	end

	sph_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tuser), .in_symbol(s_axis_tdata[63:0]),
		.in_price(s_axis_tdata[111:64]),
		.out_valid(f_valid), .out_ready(f_ready), .out_req(f_req)
	);

	sph_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	sph_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .bucket_mask(bucket_mask_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_resp(resp)
	);

	assign m_axis_tdata = {5'd0, resp.status, resp.price, resp.found};
endmodule

### hw/rtl/sph_checker.sv
// Port checker for the symbol price hash table, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sph_port_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic cfg_ready
);
	logic [1:0] out_status;
	logic [47:0] out_price;
	logic out_found;
	logic out_stall;

	assign out_status = m_axis_tdata[50:49];
	assign out_price = m_axis_tdata[48:1];
	assign out_found = m_axis_tdata[0];
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`CHK_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
	`CHK_IMPLY(a_status, clk, arst_n, m_axis_tvalid, out_status != 2'd3)
	`CHK_IMPLY(a_full_zero, clk, arst_n, m_axis_tvalid && out_status == 2'd2, !out_found && out_price == '0)
	`CHK_IMPLY(a_cfg, clk, arst_n, 1'b1, cfg_ready)
endmodule

bind symbol_price_hash_table sph_port_checker u_chk (.*);
